### rtl/core/bit_vector_extract_join_unit_defines.svh
`ifndef BIT_VECTOR_EXTRACT_JOIN_UNIT_DEFINES_SVH
`define BIT_VECTOR_EXTRACT_JOIN_UNIT_DEFINES_SVH
// Assertion macros for the bit vector extract and join unit checker.

// Concurrent assertion on the rising edge of clk that is also checked while in reset.
`define BVEJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion on the rising edge of clk that is switched off while rst is high.
`define BVEJ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### rtl/core/bvej_pkg.sv
// Shared types, operation codes and the remainder step of the bit vector extract and join unit.
`default_nettype none

package bvej_pkg;

  localparam int OP_W      = 3;
  localparam int SIZE_W    = 7;
  localparam int POS_W     = 16;
  localparam int DIV_STEPS = POS_W / 2;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [SIZE_W-1:0] vsize_t;

  localparam opcode_t OP_NOT      = 3'd0;
  localparam opcode_t OP_AND      = 3'd1;
  localparam opcode_t OP_OR       = 3'd2;
  localparam opcode_t OP_XOR      = 3'd3;
  localparam opcode_t OP_EXT_ZERO = 3'd4;
  localparam opcode_t OP_EXT_WRAP = 3'd5;
  localparam opcode_t OP_JOIN     = 3'd6;

  // Control fields that travel with a request down the pipeline.
  typedef struct packed {
    opcode_t op;
    logic    err;
    vsize_t  vsize;
    vsize_t  osize;
    vsize_t  rsize;
    logic    neg;
    logic    zf_kill;
  } ctrl_t;

  // One step of a restoring remainder: bring in the next dividend bit and subtract once.
  function automatic vsize_t mod_step(input vsize_t rem, input logic din, input vsize_t dvs);
    logic [SIZE_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      t = t - {1'b0, dvs};
    end
    return t[SIZE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/bit_vector_extract_join_unit.sv
// Top level of the bit vector extract and join unit: stream ports and the four-stage pipeline.
//
// Each request on the slave stream carries an operation, two source vectors, the vector
// size, an output size and a signed position; each one yields exactly one result on the
// master stream: the result vector, its size and a status flag (set for a bad request,
// with the vector and size then zero). The operations are NOT, AND, OR, XOR, extract
// with zero fill, extract with wrap-around and join at a split point.
// The pipeline has four register stages: decode and masking, periodic extension of the
// source with the upper half of the position remainder, the lower half of the remainder
// with the choice of shift distance, and the barrel shifter feeding the output register.
// An accepted request moves through the decode, wrapgen, align and shift registers to
// m_tvalid; one request is taken per cycle while m_tready is high, and the depth is set by
// the remainder of the position over the vector size, eight steps in each of two stages.
// Reset clears every stage's valid bit, so m_tvalid is low after reset and no result
// emerges until a new request is accepted. When the receiver holds m_tready low the
// output register keeps its result; earlier stages go on filling empty slots, and
// s_tready drops only once all four stages hold a request.
`default_nettype none

module bit_vector_extract_join_unit #(
  parameter int VEC_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // operation, first_bits, second_bits, vec_size, out_size, position; zero padded
  input  logic [((2*VEC_BITS+33+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // result_bits, result_size; zero padded
  output logic [((VEC_BITS+7+7)/8)*8-1:0]        m_tdata,
  // status
  output logic [0:0]                             m_tuser
);

  localparam int SH_W    = $clog2(2*VEC_BITS);
  localparam int OUT_W   = ((VEC_BITS + 7 + 7) / 8) * 8;
  localparam int OFS_A   = bvej_pkg::OP_W;
  localparam int OFS_B   = OFS_A + VEC_BITS;
  localparam int OFS_VS  = OFS_B + VEC_BITS;
  localparam int OFS_OS  = OFS_VS + bvej_pkg::SIZE_W;
  localparam int OFS_POS = OFS_OS + bvej_pkg::SIZE_W;

  // Request fields unpacked from the slave stream.
  bvej_pkg::opcode_t                  operation;
  logic [VEC_BITS-1:0]                first_bits;
  logic [VEC_BITS-1:0]                second_bits;
  bvej_pkg::vsize_t                   vec_size;
  bvej_pkg::vsize_t                   out_size;
  logic signed [bvej_pkg::POS_W-1:0]  position;

  assign operation   = s_tdata[0 +: bvej_pkg::OP_W];
  assign first_bits  = s_tdata[OFS_A +: VEC_BITS];
  assign second_bits = s_tdata[OFS_B +: VEC_BITS];
  assign vec_size    = s_tdata[OFS_VS +: bvej_pkg::SIZE_W];
  assign out_size    = s_tdata[OFS_OS +: bvej_pkg::SIZE_W];
  assign position    = $signed(s_tdata[OFS_POS +: bvej_pkg::POS_W]);

  // Stage one to stage two.
  logic                          v1;
  logic                          r2;
  bvej_pkg::ctrl_t               ctrl1;
  logic [VEC_BITS-1:0]           vec_a1;
  logic [VEC_BITS-1:0]           lres1;
  logic [bvej_pkg::POS_W-1:0]    dividend1;
  logic [SH_W-1:0]               zf1;

  // Stage two to stage three.
  logic                          v2;
  logic                          r3;
  bvej_pkg::ctrl_t               ctrl2;
  logic [2*VEC_BITS-1:0]         src2;
  logic [VEC_BITS-1:0]           lres2;
  logic [bvej_pkg::DIV_STEPS-1:0] div_lo2;
  bvej_pkg::vsize_t              rem_hi2;
  logic [SH_W-1:0]               zf2;

  // Stage three to stage four.
  logic                          v3;
  logic                          r4;
  bvej_pkg::ctrl_t               ctrl3;
  logic [2*VEC_BITS-1:0]         src3;
  logic [VEC_BITS-1:0]           lres3;
  logic [SH_W-1:0]               amt3;

  // Output register contents.
  logic [VEC_BITS-1:0]           result_bits;
  bvej_pkg::vsize_t              result_size;
  logic                          status;

  bvej_decode #(.VEC_BITS(VEC_BITS)) u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .operation   (operation),
    .first_bits  (first_bits),
    .second_bits (second_bits),
    .vec_size    (vec_size),
    .out_size    (out_size),
    .position    (position),
    .out_valid   (v1),
    .out_ready   (r2),
    .out_ctrl    (ctrl1),
    .vec_a       (vec_a1),
    .logic_res   (lres1),
    .dividend    (dividend1),
    .shift_zf    (zf1)
  );

  bvej_wrapgen #(.VEC_BITS(VEC_BITS)) u_wrapgen (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v1),
    .in_ready      (r2),
    .in_ctrl       (ctrl1),
    .vec_a         (vec_a1),
    .in_logic_res  (lres1),
    .dividend      (dividend1),
    .in_shift_zf   (zf1),
    .out_valid     (v2),
    .out_ready     (r3),
    .out_ctrl      (ctrl2),
    .src           (src2),
    .out_logic_res (lres2),
    .div_lo        (div_lo2),
    .rem_hi        (rem_hi2),
    .out_shift_zf  (zf2)
  );

  bvej_align #(.VEC_BITS(VEC_BITS)) u_align (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v2),
    .in_ready      (r3),
    .in_ctrl       (ctrl2),
    .in_src        (src2),
    .in_logic_res  (lres2),
    .div_lo        (div_lo2),
    .rem_hi        (rem_hi2),
    .shift_zf      (zf2),
    .out_valid     (v3),
    .out_ready     (r4),
    .out_ctrl      (ctrl3),
    .out_src       (src3),
    .out_logic_res (lres3),
    .shift_amt     (amt3)
  );

  bvej_shift #(.VEC_BITS(VEC_BITS)) u_shift (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v3),
    .in_ready    (r4),
    .in_ctrl     (ctrl3),
    .src         (src3),
    .logic_res   (lres3),
    .shift_amt   (amt3),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result_bits (result_bits),
    .result_size (result_size),
    .status      (status)
  );

  // The size sits directly above the vector; the padding bits above it read as zero.
  assign m_tdata = OUT_W'({result_size, result_bits});
  assign m_tuser = status;

endmodule

`default_nettype wire

### rtl/core/bvej_decode.sv
// First stage: size clamping, source masking, bitwise and join results, error checks.
`default_nettype none

module bvej_decode #(
  parameter int VEC_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bvej_pkg::opcode_t                      operation,
  input  logic [VEC_BITS-1:0]                    first_bits,
  input  logic [VEC_BITS-1:0]                    second_bits,
  input  bvej_pkg::vsize_t                       vec_size,
  input  bvej_pkg::vsize_t                       out_size,
  input  logic signed [bvej_pkg::POS_W-1:0]      position,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bvej_pkg::ctrl_t                        out_ctrl,
  output logic [VEC_BITS-1:0]                    vec_a,
  output logic [VEC_BITS-1:0]                    logic_res,
  output logic [bvej_pkg::POS_W-1:0]             dividend,
  output logic [$clog2(2*VEC_BITS)-1:0]          shift_zf
);

  localparam int SH_W = $clog2(2*VEC_BITS);

  bvej_pkg::vsize_t      vs;
  bvej_pkg::vsize_t      os;
  logic [VEC_BITS-1:0]   vmask;
  logic [VEC_BITS-1:0]   jmask;
  logic [VEC_BITS-1:0]   a;
  logic [VEC_BITS-1:0]   b;
  logic [VEC_BITS-1:0]   lres;
  logic                  join_ok;
  bvej_pkg::ctrl_t       c;

  always_comb begin
    vs = (vec_size > bvej_pkg::SIZE_W'(VEC_BITS)) ? bvej_pkg::SIZE_W'(VEC_BITS) : vec_size;
    os = (out_size > bvej_pkg::SIZE_W'(VEC_BITS)) ? bvej_pkg::SIZE_W'(VEC_BITS) : out_size;
    for (int k = 0; k < VEC_BITS; k++) begin
      vmask[k] = bvej_pkg::SIZE_W'(k) < vs;
      jmask[k] = $signed(bvej_pkg::POS_W'(k)) < position;
    end
    a = first_bits & vmask;
    b = second_bits & vmask;
    join_ok = !position[bvej_pkg::POS_W-1] &&
              ($unsigned(position) <= bvej_pkg::POS_W'(vs));

    c.op      = operation;
    c.vsize   = vs;
    c.osize   = os;
    c.rsize   = vs;
    c.neg     = position[bvej_pkg::POS_W-1];
    c.zf_kill = (int'(position) <= -VEC_BITS) || (int'(position) >= VEC_BITS);
    c.err     = (vs == '0);
    lres      = '0;
    unique case (operation)
      bvej_pkg::OP_NOT: lres = ~a & vmask;
      bvej_pkg::OP_AND: lres = a & b;
      bvej_pkg::OP_OR:  lres = a | b;
      bvej_pkg::OP_XOR: lres = a ^ b;
      bvej_pkg::OP_EXT_ZERO, bvej_pkg::OP_EXT_WRAP: begin
        c.rsize = os;
        if (os == '0) begin
          c.err = 1'b1;
        end
      end
      bvej_pkg::OP_JOIN: begin
        lres = (a & jmask) | (b & ~jmask);
        if (!join_ok) begin
          c.err = 1'b1;
        end
      end
      default: c.err = 1'b1;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctrl  <= c;
      vec_a     <= a;
      logic_res <= lres;
      dividend  <= position[bvej_pkg::POS_W-1] ? $unsigned(-position) : $unsigned(position);
      shift_zf  <= SH_W'(VEC_BITS + int'(position));
    end
  end

endmodule

`default_nettype wire

### rtl/core/bvej_wrapgen.sv
// Second stage: periodic extension of the source for wrap extracts and upper remainder steps.
`default_nettype none

module bvej_wrapgen #(
  parameter int VEC_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bvej_pkg::ctrl_t                        in_ctrl,
  input  logic [VEC_BITS-1:0]                    vec_a,
  input  logic [VEC_BITS-1:0]                    in_logic_res,
  input  logic [bvej_pkg::POS_W-1:0]             dividend,
  input  logic [$clog2(2*VEC_BITS)-1:0]          in_shift_zf,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bvej_pkg::ctrl_t                        out_ctrl,
  output logic [2*VEC_BITS-1:0]                  src,
  output logic [VEC_BITS-1:0]                    out_logic_res,
  output logic [bvej_pkg::DIV_STEPS-1:0]         div_lo,
  output bvej_pkg::vsize_t                       rem_hi,
  output logic [$clog2(2*VEC_BITS)-1:0]          out_shift_zf
);

  localparam int IDX_W = $clog2(VEC_BITS);

  bvej_pkg::vsize_t     vm1;
  logic [IDX_W-1:0]     vidx;
  wire [2*VEC_BITS-1:0] ext;
  bvej_pkg::vsize_t     rem;

  assign vm1  = in_ctrl.vsize - bvej_pkg::SIZE_W'(1);
  assign vidx = vm1[IDX_W-1:0];

  // ext[k] is source bit k mod vsize: for each k a selector over every possible size.
  for (genvar k = 0; k < 2*VEC_BITS; k++) begin : g_ext
    wire [VEC_BITS-1:0] cand;
    for (genvar d = 1; d <= VEC_BITS; d++) begin : g_div
      localparam int Idx = k % d;
      assign cand[d-1] = vec_a[Idx];
    end
    assign ext[k] = cand[vidx];
  end

  always_comb begin
    rem = '0;
    for (int j = bvej_pkg::DIV_STEPS - 1; j >= 0; j--) begin
      rem = bvej_pkg::mod_step(rem, dividend[bvej_pkg::DIV_STEPS + j], in_ctrl.vsize);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctrl      <= in_ctrl;
      src           <= (in_ctrl.op == bvej_pkg::OP_EXT_WRAP) ? ext : {vec_a, {VEC_BITS{1'b0}}};
      out_logic_res <= in_logic_res;
      div_lo        <= dividend[bvej_pkg::DIV_STEPS-1:0];
      rem_hi        <= rem;
      out_shift_zf  <= in_shift_zf;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bvej_align.sv
// Third stage: lower remainder steps, sign correction and choice of the shift distance.
`default_nettype none

module bvej_align #(
  parameter int VEC_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bvej_pkg::ctrl_t                        in_ctrl,
  input  logic [2*VEC_BITS-1:0]                  in_src,
  input  logic [VEC_BITS-1:0]                    in_logic_res,
  input  logic [bvej_pkg::DIV_STEPS-1:0]         div_lo,
  input  bvej_pkg::vsize_t                       rem_hi,
  input  logic [$clog2(2*VEC_BITS)-1:0]          shift_zf,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bvej_pkg::ctrl_t                        out_ctrl,
  output logic [2*VEC_BITS-1:0]                  out_src,
  output logic [VEC_BITS-1:0]                    out_logic_res,
  output logic [$clog2(2*VEC_BITS)-1:0]          shift_amt
);

  localparam int SH_W = $clog2(2*VEC_BITS);

  bvej_pkg::vsize_t rem;
  bvej_pkg::vsize_t wrap_r;
  logic [SH_W-1:0]  amt;

  always_comb begin
    rem = rem_hi;
    for (int j = bvej_pkg::DIV_STEPS - 1; j >= 0; j--) begin
      rem = bvej_pkg::mod_step(rem, div_lo[j], in_ctrl.vsize);
    end
    // A negative start folds back into 0..vsize-1.
    wrap_r = (in_ctrl.neg && (rem != '0)) ? in_ctrl.vsize - rem : rem;
    amt    = (in_ctrl.op == bvej_pkg::OP_EXT_WRAP) ? SH_W'(wrap_r) : shift_zf;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctrl      <= in_ctrl;
      out_src       <= in_src;
      out_logic_res <= in_logic_res;
      shift_amt     <= amt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bvej_shift.sv
// Fourth stage: barrel shift, output size masking, result selection and the output register.
`default_nettype none

module bvej_shift #(
  parameter int VEC_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bvej_pkg::ctrl_t                        in_ctrl,
  input  logic [2*VEC_BITS-1:0]                  src,
  input  logic [VEC_BITS-1:0]                    logic_res,
  input  logic [$clog2(2*VEC_BITS)-1:0]          shift_amt,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [VEC_BITS-1:0]                    result_bits,
  output bvej_pkg::vsize_t                       result_size,
  output logic                                   status
);

  logic [2*VEC_BITS-1:0] shifted;
  logic [VEC_BITS-1:0]   omask;
  logic [VEC_BITS-1:0]   res;
  logic                  is_ext;
  logic                  kill;

  always_comb begin
    shifted = src >> shift_amt;
    for (int k = 0; k < VEC_BITS; k++) begin
      omask[k] = bvej_pkg::SIZE_W'(k) < in_ctrl.osize;
    end
    is_ext = (in_ctrl.op == bvej_pkg::OP_EXT_ZERO) || (in_ctrl.op == bvej_pkg::OP_EXT_WRAP);
    kill   = (in_ctrl.op == bvej_pkg::OP_EXT_ZERO) && in_ctrl.zf_kill;
    if (in_ctrl.err || kill) begin
      res = '0;
    end else if (is_ext) begin
      res = shifted[VEC_BITS-1:0] & omask;
    end else begin
      res = logic_res;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result_bits <= res;
      result_size <= in_ctrl.err ? '0 : in_ctrl.rsize;
      status      <= in_ctrl.err;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bvej_checker.sv
// Port-level checker for the bit vector extract and join unit, with its bind statement.
`default_nettype none
`include "bit_vector_extract_join_unit_defines.svh"

module bvej_checker #(
  parameter int VEC_BITS = 64
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [((VEC_BITS+7+7)/8)*8-1:0]    m_tdata,
  input logic [0:0]                         m_tuser
);

  // Reset empties the pipeline, so no result can be offered just after it.
  `BVEJ_ASSERT(a_reset_empty, rst |=> !m_tvalid, "result offered right after reset")

  // A flagged request must come out with a zero vector and a zero size.
  `BVEJ_ASSERT_RST(a_err_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0, "error result not zero")

  // A good result always has a non-zero size.
  `BVEJ_ASSERT_RST(a_ok_size, m_tvalid && !m_tuser[0] |-> m_tdata[VEC_BITS +: bvej_pkg::SIZE_W] != '0, "good result with zero size")

  // With the receiver ready throughout, an accepted request passes the stage registers and is offered on m_tvalid.
  `BVEJ_ASSERT_RST(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "request lost in the pipeline")

  // A stalled result stays offered and unchanged.
  `BVEJ_ASSERT_RST(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind bit_vector_extract_join_unit bvej_checker #(.VEC_BITS(VEC_BITS)) u_bvej_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the bit vector extract and join unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB          = 64;
  localparam int DATA_W      = ((2*VB+33+7)/8)*8;
  localparam int RES_W       = ((VB+7+7)/8)*8;
  localparam int N_RANDOM    = 1000;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_AT    = 600;
  localparam int CYCLE_LIMIT = 300000;

  // The one code that the unit leaves unused; it must be rejected.
  localparam bvej_pkg::opcode_t OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  size;
    logic        status;
  } result_t;

  typedef struct packed {
    bvej_pkg::opcode_t op;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [6:0]        vs;
    logic [6:0]        os;
    logic [15:0]       pos;
    logic              known;
    result_t           res;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [RES_W-1:0]  m_tdata;
  logic [0:0]        m_tuser;

  // Set with each request: whether its result is typed in and, if so, what it is.
  logic    row_known;
  result_t row_exp;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        cycle_count;
  bit        hold_req;
  bit        quiet;

  bit_vector_extract_join_unit #(.VEC_BITS(VB)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request layout from the lowest bit: operation, first, second, vec_size, out_size,
  // position, then zero padding up to a whole byte.
  function automatic logic [DATA_W-1:0] pack_request(input bvej_pkg::opcode_t op,
                                                     input logic [63:0] a,
                                                     input logic [63:0] b, input logic [6:0] vs,
                                                     input logic [6:0] os,
                                                     input logic [15:0] pos);
    logic [DATA_W-1:0] d;
    d = '0;
    d[2:0]     = op;
    d[66:3]    = a;
    d[130:67]  = b;
    d[137:131] = vs;
    d[144:138] = os;
    d[160:145] = pos;
    return d;
  endfunction

  // Works out the result of one request straight from its packed form.
  function automatic result_t extract_join_result(input logic [DATA_W-1:0] req);
    result_t           r;
    bvej_pkg::opcode_t op;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [63:0]       vmask;
    logic [63:0]       lo;
    int                vsz;
    int                osz;
    int                pos;
    int                p;
    logic              err;
    op    = req[2:0];
    a     = req[66:3];
    b     = req[130:67];
    vsz   = int'(req[137:131]);
    osz   = int'(req[144:138]);
    pos   = int'($signed(req[160:145]));
    if (vsz > VB) vsz = VB;
    if (osz > VB) osz = VB;
    vmask = (vsz >= 64) ? '1 : ((64'd1 << vsz) - 64'd1);
    a     = a & vmask;
    b     = b & vmask;
    r     = '0;
    r.size = 7'(vsz);
    err   = (vsz == 0);
    if (!err) begin
      case (op)
        bvej_pkg::OP_NOT: begin
          r.bits = ~a & vmask;
        end
        bvej_pkg::OP_AND: begin
          r.bits = a & b;
        end
        bvej_pkg::OP_OR: begin
          r.bits = a | b;
        end
        bvej_pkg::OP_XOR: begin
          r.bits = a ^ b;
        end
        bvej_pkg::OP_EXT_ZERO, bvej_pkg::OP_EXT_WRAP: begin
          if (osz == 0) begin
            err = 1'b1;
          end else begin
            r.size = 7'(osz);
            for (int i = 0; i < osz; i++) begin
              p = pos + i;
              if (op == bvej_pkg::OP_EXT_WRAP) begin
                // The remainder truncates towards zero, so fold negatives back in range.
                p = p % vsz;
                if (p < 0) p = p + vsz;
                r.bits[i] = a[p];
              end else if (p >= 0 && p < vsz) begin
                r.bits[i] = a[p];
              end
            end
          end
        end
        bvej_pkg::OP_JOIN: begin
          if (pos < 0 || pos > vsz) begin
            err = 1'b1;
          end else begin
            lo     = (pos >= 64) ? '1 : ((64'd1 << pos) - 64'd1);
            r.bits = ((a & lo) | (b & ~lo)) & vmask;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
    if (err) begin
      r.bits = '0;
      r.size = '0;
    end
    r.status = err;
    return r;
  endfunction

  task automatic add_row(input bvej_pkg::opcode_t op, input logic [63:0] a,
                         input logic [63:0] b,
                         input int vs, input int os, input int pos, input logic known,
                         input logic [63:0] ebits, input int esize, input logic estat);
    stim_row_t row;
    row.op         = op;
    row.a          = a;
    row.b          = b;
    row.vs         = 7'(vs);
    row.os         = 7'(os);
    row.pos        = 16'(pos);
    row.known      = known;
    row.res.bits   = ebits;
    row.res.size   = 7'(esize);
    row.res.status = estat;
    directed_rows.push_back(row);
  endtask

  // Offers one request from the falling edge on and returns once it has been taken.
  task automatic send_request(input logic [DATA_W-1:0] data, input logic known,
                              input result_t typed, input bit may_idle);
    int gap;
    @(negedge clk);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    s_tdata   = data;
    row_known = known;
    row_exp   = typed;
    s_tvalid  = 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stimulus: reset, the directed table, then random requests, then the drain.
  initial begin : stimulus
    logic [63:0]       a;
    logic [63:0]       b;
    bvej_pkg::opcode_t op;
    int                vs;
    int                os;
    int                pos;
    int                vs_eff;
    int                sel;
    stim_row_t         row;
    result_t           none;
    int                k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    row_known = 1'b0;
    row_exp   = '0;
    errors    = 0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    none      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes of every field, every operation and each named special case. Rows with
    // an obvious answer carry it; the rest go to the predictor.
    add_row(bvej_pkg::OP_NOT, 64'h0, 64'h0, 64, 1, 0, 1'b1, '1, 64, 1'b0);
    add_row(bvej_pkg::OP_NOT, '1, '1, 64, 64, -1, 1'b1, 64'h0, 64, 1'b0);
    // NOT clears everything above the vector size.
    add_row(bvej_pkg::OP_NOT, 64'h0, 64'h0, 8, 0, 0, 1'b1, 64'hFF, 8, 1'b0);
    add_row(bvej_pkg::OP_AND, '1, '1, 64, 0, 0, 1'b1, '1, 64, 1'b0);
    // Source bits above the size are ignored.
    add_row(bvej_pkg::OP_OR, 64'hF0F0_1234_5678_9ABC, 64'h0F0F_FFFF_0000_1111, 37, 5, 3,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_XOR, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 64, 9, 7,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_EXT_ZERO, 64'hA5A5_5A5A_C3C3_3C3C, 64'h0, 64, 64, 0,
            1'b0, 64'h0, 0, 1'b0);
    // Shifts: zero-fill extract at minus the shift with out_size equal to vec_size.
    add_row(bvej_pkg::OP_EXT_ZERO, 64'h000F_FFFF_0ABC_DEF1, 64'h0, 20, 20, -5,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_EXT_ZERO, 64'h000F_FFFF_0ABC_DEF1, 64'h0, 20, 20, 5,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_EXT_ZERO, '1, '1, 64, 64, -32768, 1'b1, 64'h0, 64, 1'b0);
    add_row(bvej_pkg::OP_EXT_ZERO, '1, '1, 64, 10, 32767, 1'b1, 64'h0, 10, 1'b0);
    add_row(bvej_pkg::OP_EXT_WRAP, 64'h0000_0000_0000_8001, 64'h0, 16, 16, -1,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_EXT_WRAP, 64'h8000_0000_0000_0001, 64'h0, 64, 64, -32768,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_EXT_WRAP, 64'h0000_0000_0000_0055, 64'h0, 7, 40, 32767,
            1'b0, 64'h0, 0, 1'b0);
    // Zero out_size is refused by both extracts.
    add_row(bvej_pkg::OP_EXT_ZERO, '1, '1, 64, 0, 0, 1'b1, 64'h0, 0, 1'b1);
    add_row(bvej_pkg::OP_EXT_WRAP, '1, '1, 64, 0, 0, 1'b1, 64'h0, 0, 1'b1);
    add_row(bvej_pkg::OP_JOIN, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 64, 3, 0,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_JOIN, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 64, 3, 64,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_JOIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_00AA_AAAA_AAAA, 40, 1, 30,
            1'b0, 64'h0, 0, 1'b0);
    // Join positions just outside 0..size.
    add_row(bvej_pkg::OP_JOIN, '1, '1, 40, 1, -1, 1'b1, 64'h0, 0, 1'b1);
    add_row(bvej_pkg::OP_JOIN, '1, '1, 40, 1, 41, 1'b1, 64'h0, 0, 1'b1);
    // Zero vector size and the unused operation code.
    add_row(bvej_pkg::OP_AND, '1, '1, 0, 5, 0, 1'b1, 64'h0, 0, 1'b1);
    add_row(OP_UNUSED, '1, '1, 64, 64, 0, 1'b1, 64'h0, 0, 1'b1);
    // Oversized sizes saturate to the full width.
    add_row(bvej_pkg::OP_EXT_WRAP, 64'h0123_4567_89AB_CDEF, 64'h0, 127, 127, 100,
            1'b0, 64'h0, 0, 1'b0);
    add_row(bvej_pkg::OP_NOT, 64'h0, 64'h0, 100, 127, 0, 1'b1, '1, 64, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(pack_request(row.op, row.a, row.b, row.vs, row.os, row.pos),
                   row.known, row.res, 1'b1);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 15);
      a   = {$urandom, $urandom};
      b   = {$urandom, $urandom};
      case ($urandom_range(0, 15))
        0: a = '0;
        1: a = '1;
        2: b = '0;
        3: b = '1;
        default: ;
      endcase
      vs = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      os = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      vs_eff = (vs > VB) ? VB : vs;
      pos = $signed(16'($urandom));
      if (sel <= 3) begin
        op = bvej_pkg::opcode_t'(sel);
      end else if (sel <= 9) begin
        op = (sel <= 6) ? bvej_pkg::OP_EXT_ZERO : bvej_pkg::OP_EXT_WRAP;
        if ($urandom_range(0, 7) != 0) pos = int'($urandom_range(0, 200)) - 100;
      end else if (sel <= 12) begin
        op = bvej_pkg::OP_JOIN;
        if ($urandom_range(0, 7) != 0) pos = $urandom_range(0, vs_eff);
        else if ($urandom_range(0, 1) == 0) pos = vs_eff + 1;
      end else if (sel == 13) begin
        op = bvej_pkg::opcode_t'($urandom_range(0, 7));
      end else begin
        // Shift left or right within the vector.
        op  = bvej_pkg::OP_EXT_ZERO;
        os  = vs;
        pos = int'($urandom_range(0, 2 * vs_eff)) - vs_eff;
      end

      if (k == HOLD_AT) hold_req = 1'b1;
      if (k == DRAIN_AT) begin
        // Withdraw the last request so that it is not taken again while draining.
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (k == N_RANDOM - QUIET_TAIL) quiet = 1'b1;

      send_request(pack_request(op, a, b, 7'(vs), 7'(os), 16'(pos)), 1'b0, none,
                   !quiet && !(k >= HOLD_AT && k < HOLD_AT + 100));
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none near the end.
  initial begin : receiver
    int hold_cnt;
    bit hold_taken;
    hold_taken = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready   = 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        m_tready = 1'b1;
      end else if (quiet || rst || $urandom_range(0, 5) != 0) begin
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        m_tready = 1'b1;
      end
    end
  end

  // Records the expected result of every accepted request and checks every result.
  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (row_known) pending_results.push_back(row_exp);
        else pending_results.push_back(extract_join_result(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.bits   = m_tdata[63:0];
        got.size   = m_tdata[70:64];
        got.status = m_tuser[0];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: bits %h size %0d status %0d",
                   $time, got.bits, got.size, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.bits !== want.bits) begin
            errors++;
            $display("%0t: result_bits expected %h actual %h", $time, want.bits, got.bits);
          end
          if (got.size !== want.size) begin
            errors++;
            $display("%0t: result_size expected %0d actual %0d", $time, want.size, got.size);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

### bit_vector_extract_join_unit.f
+incdir+rtl/core
rtl/core/bvej_pkg.sv
rtl/core/bvej_decode.sv
rtl/core/bvej_wrapgen.sv
rtl/core/bvej_align.sv
rtl/core/bvej_shift.sv
rtl/core/bit_vector_extract_join_unit.sv
rtl/core/bvej_checker.sv
dv/tb.sv
